### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the peak meter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define WPDM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WPDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`WPDM_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### sv/wpdm_pkg.sv
// ----------------------------------------------------------------------------
// Peak meter package
// Widths, constants, state codes and shared types of the peak meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpdm_pkg;

	localparam int CODE_W      = 12;
	localparam int GAIN_W      = 16;
	localparam int OUT_W       = 10;
	localparam int MUL_W       = CODE_W + GAIN_W;
	localparam int MILLI_SHIFT = 12;
	localparam int VOLT_SHIFT  = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd12231;
	localparam logic [GAIN_W-1:0] MILLI_SCALE = 16'd1000;
	localparam logic [OUT_W-1:0]  VOLT_MAX    = 10'd1023;
	localparam logic [OUT_W-1:0]  MILLI_MAX   = 10'd999;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_MULV  = 7'b0001000,
		ST_MULL  = 7'b0010000,
		ST_MULN  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic              en;
		logic [CODE_W-1:0] a;
		logic [GAIN_W-1:0] b;
	} mul_req_t;

	function automatic logic [CODE_W-1:0] abs_diff(input logic [CODE_W-1:0] x,
	                                               input logic [CODE_W-1:0] y);
		abs_diff = (x >= y) ? (x - y) : (y - x);
	endfunction

endpackage

### sv/wpdm_ring.sv
// ----------------------------------------------------------------------------
// Peak meter sample ring
// One-write, one-read memory of paired line and neutral codes, read registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpdm_ring #(
	parameter int DEPTH  = 200,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/wpdm_mul.sv
// ----------------------------------------------------------------------------
// Peak meter shared multiplier
// One registered code by gain multiplier, loaded only when requested.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpdm_mul (
	input  logic                      clk,
	input  wpdm_pkg::mul_req_t        req,
	output logic [wpdm_pkg::MUL_W-1:0] product
);

	import wpdm_pkg::*;

	logic [MUL_W-1:0] product_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			product_q <= MUL_W'(req.a) * MUL_W'(req.b);
		end
	end

	assign product = product_q;

endmodule

### sv/windowed_differential_peak_meter_unit.sv
// ----------------------------------------------------------------------------
// Windowed differential peak meter
// Ring of line and neutral samples with a peak scan and scaled readout.
// ----------------------------------------------------------------------------
// A store item is written in the cycle it is taken and the block is ready again in the next one. A query
// item is offered as a result only after the scan and the readout: the scan reads the
// sample ring through its single read port one entry per cycle, and the voltage and both
// thousandth readings then pass one after another through a single shared multiplier.
// The ring is not swept after reset; a fill count marks entries not yet written, which
// read as zero. Stores are accepted while a result waits on the output.
`timescale 1ns / 1ps

module windowed_differential_peak_meter_unit #(
	parameter int WINDOW_DEPTH = 200
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [wpdm_pkg::GAIN_W-1:0]   cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [wpdm_pkg::CODE_W-1:0]   line_sample,
	input  logic [wpdm_pkg::CODE_W-1:0]   neutral_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wpdm_pkg::OUT_W-1:0]    peak_voltage,
	output logic [wpdm_pkg::OUT_W-1:0]    line_milli,
	output logic [wpdm_pkg::OUT_W-1:0]    neutral_milli
);

	import wpdm_pkg::*;

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int PAIR_W = 2 * CODE_W;

	state_t state_q;

	logic [GAIN_W-1:0] gain_q;
	logic [ADDR_W-1:0] wr_idx_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] addr_q;
	logic              scan_vld_s1;
	logic              live_s1;
	logic [CODE_W-1:0] best_q;
	logic [CODE_W-1:0] held_line_q;
	logic [CODE_W-1:0] held_neutral_q;
	logic [OUT_W-1:0]  volt_q;
	logic [OUT_W-1:0]  lmilli_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_volt_q;
	logic [OUT_W-1:0]  out_lmilli_q;
	logic [OUT_W-1:0]  out_nmilli_q;

	logic              accept;
	logic              store_we;
	logic              scan_re;
	logic [PAIR_W-1:0] rd_pair;
	logic [CODE_W-1:0] rd_line;
	logic [CODE_W-1:0] rd_neutral;
	logic [CODE_W-1:0] rd_gap;
	logic [CODE_W-1:0] held_gap;
	mul_req_t          mul_req;
	logic [MUL_W-1:0]  product;
	logic [MUL_W-VOLT_SHIFT-1:0] volt_full;
	logic              out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign store_we = accept && (command == CMD_STORE);
	assign scan_re  = (state_q == ST_SCAN);
	assign out_free = !out_valid_q || !out_stall;

	wpdm_ring #(
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (PAIR_W)
	) u_ring (
		.clk   (clk),
		.we    (store_we),
		.waddr (wr_idx_q),
		.wdata ({line_sample, neutral_sample}),
		.re    (scan_re),
		.raddr (addr_q),
		.rdata (rd_pair)
	);

	assign rd_line    = rd_pair[PAIR_W-1:CODE_W];
	assign rd_neutral = rd_pair[CODE_W-1:0];
	assign rd_gap     = abs_diff(rd_line, rd_neutral);
	assign held_gap   = abs_diff(held_line_q, held_neutral_q);

	always_comb begin
		mul_req = '{en: 1'b0, a: held_gap, b: gain_q};
		case (state_q)
			ST_MULV: begin
				mul_req = '{en: 1'b1, a: held_gap, b: gain_q};
			end
			ST_MULL: begin
				mul_req = '{en: 1'b1, a: held_line_q, b: MILLI_SCALE};
			end
			ST_MULN: begin
				mul_req = '{en: 1'b1, a: held_neutral_q, b: MILLI_SCALE};
			end
			default: begin
				mul_req = '{en: 1'b0, a: held_gap, b: gain_q};
			end
		endcase
	end

	wpdm_mul u_mul (
		.clk     (clk),
		.req     (mul_req),
		.product (product)
	);

	assign volt_full = product[MUL_W-1:VOLT_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			gain_q         <= GAIN_RESET;
			wr_idx_q       <= '0;
			fill_q         <= '0;
			addr_q         <= '0;
			scan_vld_s1    <= 1'b0;
			live_s1        <= 1'b0;
			best_q         <= '0;
			held_line_q    <= '0;
			held_neutral_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				gain_q <= cfg_write_data;
			end
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			scan_vld_s1 <= scan_re;
			live_s1     <= (FILL_W'(addr_q) < fill_q);
			if (scan_vld_s1 && live_s1 && (rd_gap > best_q)) begin
				best_q         <= rd_gap;
				held_line_q    <= rd_line;
				held_neutral_q <= rd_neutral;
			end
			case (state_q)
				ST_IDLE: begin
					if (store_we) begin
						wr_idx_q <= (wr_idx_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
						if (fill_q != FILL_W'(WINDOW_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end else if (accept) begin
						best_q  <= '0;
						addr_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == ADDR_W'(WINDOW_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MULV;
				end
				ST_MULV: begin
					state_q <= ST_MULL;
				end
				ST_MULL: begin
					state_q <= ST_MULN;
				end
				ST_MULN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MULL) begin
			volt_q <= (volt_full > (MUL_W-VOLT_SHIFT)'(VOLT_MAX)) ?
			          VOLT_MAX : volt_full[OUT_W-1:0];
		end
		if (state_q == ST_MULN) begin
			lmilli_q <= product[MILLI_SHIFT+OUT_W-1:MILLI_SHIFT];
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_volt_q   <= volt_q;
			out_lmilli_q <= lmilli_q;
			out_nmilli_q <= product[MILLI_SHIFT+OUT_W-1:MILLI_SHIFT];
		end
	end

	assign out_valid     = out_valid_q;
	assign peak_voltage  = out_volt_q;
	assign line_milli    = out_lmilli_q;
	assign neutral_milli = out_nmilli_q;

endmodule

### sv/wpdm_checker.sv
// ----------------------------------------------------------------------------
// Peak meter port checker
// Concurrent checks on the peak meter ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wpdm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        command,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [wpdm_pkg::OUT_W-1:0]  peak_voltage,
	input logic [wpdm_pkg::OUT_W-1:0]  line_milli,
	input logic [wpdm_pkg::OUT_W-1:0]  neutral_milli
);

	import wpdm_pkg::*;

	`WPDM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(peak_voltage), "stalled result item changed")
	`WPDM_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && !in_stall && (command == CMD_QUERY), in_stall, "query item did not occupy the block")
	`WPDM_ASSERT_NEXT(a_store_silent, clk, arst_n, in_valid && !in_stall && (command == CMD_STORE) && !out_valid, !out_valid, "store item produced a result item")
	`WPDM_ASSERT(a_milli_range, clk, arst_n, !out_valid || ((line_milli <= MILLI_MAX) && (neutral_milli <= MILLI_MAX)), "milli reading out of range")

endmodule

bind windowed_differential_peak_meter_unit wpdm_checker u_wpdm_checker (.*);

### test/tb.sv
// ----------------------------------------------------------------------------
// Peak meter testbench
// Drives store and query items into the windowed differential peak meter
// through a stimulus table and then phases of random items, each phase
// with its own gain and its own pattern of sender gaps and receiver stalls.
// A local model of the sample ring, the held peak pair and the gain
// predicts each reading, and the scoreboard checks every field of each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import wpdm_pkg::*;

	localparam int WINDOW_DEPTH = 200;
	localparam int SETTLE_CYCLES = WINDOW_DEPTH + 10;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 150;
	localparam int DIR_ROWS = 18;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum int {REFILL_NONE, REFILL_FLAT, REFILL_NARROW} refill_t;

	typedef struct packed {
		logic [OUT_W-1:0] volt;
		logic [OUT_W-1:0] line_m;
		logic [OUT_W-1:0] neut_m;
	} reading_t;

	typedef struct packed {
		logic              cmd;
		logic [CODE_W-1:0] line;
		logic [CODE_W-1:0] neut;
		logic              typed;
		reading_t          want;
	} dir_row_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              rand_gain;
		idle_mode_t        mode;
		refill_t           refill;
	} phase_plan_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_write_en = 1'b0;
	logic [GAIN_W-1:0]   cfg_write_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                command = CMD_STORE;
	logic [CODE_W-1:0]   line_sample = '0;
	logic [CODE_W-1:0]   neutral_sample = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [OUT_W-1:0]    peak_voltage;
	logic [OUT_W-1:0]    line_milli;
	logic [OUT_W-1:0]    neutral_milli;

	logic [CODE_W-1:0]   ring_line [WINDOW_DEPTH];
	logic [CODE_W-1:0]   ring_neut [WINDOW_DEPTH];
	int unsigned         wr_ptr;
	logic [CODE_W-1:0]   hold_line;
	logic [CODE_W-1:0]   hold_neut;
	logic [GAIN_W-1:0]   gain_now;

	reading_t            pending_readings [$];
	int                  mismatch_count = 0;
	idle_mode_t          idle_mode = IDLE_NONE;
	dir_row_t            dir_tbl [DIR_ROWS];
	phase_plan_t         phase_plan [PHASES];

	windowed_differential_peak_meter_unit #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.line_sample(line_sample),
		.neutral_sample(neutral_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.peak_voltage(peak_voltage),
		.line_milli(line_milli),
		.neutral_milli(neutral_milli)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("%0t: timeout with %0d readings outstanding", $time, pending_readings.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int send_pct(input idle_mode_t m);
		return (m == IDLE_SEND) ? 61 : (m == IDLE_BOTH) ? 16 : 0;
	endfunction

	function automatic int recv_pct(input idle_mode_t m);
		return (m == IDLE_RECV) ? 61 : (m == IDLE_BOTH) ? 16 : 0;
	endfunction

	function automatic logic [CODE_W-1:0] code_span(input logic [CODE_W-1:0] a,
	                                                input logic [CODE_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic reading_t meter_step(input logic c, input logic [CODE_W-1:0] l,
	                                        input logic [CODE_W-1:0] n);
		reading_t          r;
		logic [CODE_W-1:0] best;
		logic [CODE_W-1:0] span;
		logic [27:0]       prod;
		logic [21:0]       lm;
		logic [21:0]       nm;
		int                k;
		r = '0;
		if (c == CMD_STORE) begin
			ring_line[wr_ptr] = l;
			ring_neut[wr_ptr] = n;
			wr_ptr = (wr_ptr == WINDOW_DEPTH - 1) ? 0 : wr_ptr + 1;
		end else begin
			best = '0;
			for (k = 0; k < WINDOW_DEPTH; k++) begin
				span = code_span(ring_line[k], ring_neut[k]);
				if (span > best) begin
					best = span;
					hold_line = ring_line[k];
					hold_neut = ring_neut[k];
				end
			end
			prod = 28'(code_span(hold_line, hold_neut)) * 28'(gain_now);
			prod = prod >> VOLT_SHIFT;
			r.volt = (prod > 28'(VOLT_MAX)) ? VOLT_MAX : prod[OUT_W-1:0];
			lm = 22'(hold_line) * 22'd1000;
			nm = 22'(hold_neut) * 22'd1000;
			r.line_m = lm[21:MILLI_SHIFT];
			r.neut_m = nm[21:MILLI_SHIFT];
		end
		return r;
	endfunction

	task automatic send_item(input logic c, input logic [CODE_W-1:0] l,
	                         input logic [CODE_W-1:0] n, input logic typed,
	                         input reading_t typed_val);
		reading_t predicted;
		while ($urandom_range(0, 99) < send_pct(idle_mode)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		line_sample <= l;
		neutral_sample <= n;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = meter_step(c, l, n);
		if (c == CMD_QUERY) begin
			pending_readings.push_back(typed ? typed_val : predicted);
		end
	endtask

	task automatic send_random_store();
		logic [CODE_W-1:0] l;
		logic [CODE_W-1:0] n;
		int unsigned       style;
		style = $urandom_range(0, 99);
		l = CODE_W'($urandom_range(0, 4095));
		n = CODE_W'($urandom_range(0, 4095));
		if (style < 12) begin
			l = $urandom_range(0, 1) ? '1 : '0;
			n = $urandom_range(0, 3) == 0 ? l : ~l;
		end else if (style < 25) begin
			n = l ^ CODE_W'($urandom_range(0, 3));
		end
		send_item(CMD_STORE, l, n, 1'b0, '0);
	endtask

	task automatic refill_window(input refill_t kind);
		logic [CODE_W-1:0] v;
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			if (kind == REFILL_FLAT) begin
				v = CODE_W'($urandom_range(0, 4095));
				send_item(CMD_STORE, v, v, 1'b0, '0);
			end else begin
				send_item(CMD_STORE, CODE_W'($urandom_range(0, 7)),
				          CODE_W'($urandom_range(0, 7)), 1'b0, '0);
			end
		end
		send_item(CMD_QUERY, '0, '0, 1'b0, '0);
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
	                                    input logic [OUT_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_pct(idle_mode));
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected reading, expected none, got %0d %0d %0d",
				         $time, peak_voltage, line_milli, neutral_milli);
			end else begin
				want = pending_readings.pop_front();
				check_field("peak_voltage", want.volt, peak_voltage);
				check_field("line_milli", want.line_m, line_milli);
				check_field("neutral_milli", want.neut_m, neutral_milli);
			end
		end
	end

	initial begin
		int sent;
		int burst;
		logic [GAIN_W-1:0] g;
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			ring_line[k] = '0;
			ring_neut[k] = '0;
		end
		wr_ptr = 0;
		hold_line = '0;
		hold_neut = '0;
		gain_now = GAIN_RESET;

		dir_tbl = '{
			'{CMD_QUERY, 12'd0,    12'd0,    1'b1, '{10'd0,   10'd0,   10'd0}},
			'{CMD_STORE, 12'd0,    12'd4095, 1'b0, '0},
			'{CMD_QUERY, 12'd0,    12'd0,    1'b1, '{10'd764, 10'd0,   10'd999}},
			'{CMD_STORE, 12'd4095, 12'd0,    1'b0, '0},
			'{CMD_QUERY, 12'd0,    12'd0,    1'b1, '{10'd764, 10'd0,   10'd999}},
			'{CMD_STORE, 12'd2048, 12'd2048, 1'b0, '0},
			'{CMD_STORE, 12'd4095, 12'd4095, 1'b0, '0},
			'{CMD_STORE, 12'd0,    12'd0,    1'b0, '0},
			'{CMD_QUERY, 12'd4095, 12'd4095, 1'b1, '{10'd764, 10'd0,   10'd999}},
			'{CMD_STORE, 12'd1,    12'd0,    1'b0, '0},
			'{CMD_STORE, 12'd0,    12'd1,    1'b0, '0},
			'{CMD_STORE, 12'd2730, 12'd1365, 1'b0, '0},
			'{CMD_STORE, 12'd1365, 12'd2730, 1'b0, '0},
			'{CMD_QUERY, 12'd0,    12'd0,    1'b0, '0},
			'{CMD_QUERY, 12'd4095, 12'd0,    1'b0, '0},
			'{CMD_STORE, 12'd4095, 12'd4094, 1'b0, '0},
			'{CMD_STORE, 12'd3000, 12'd100,  1'b0, '0},
			'{CMD_QUERY, 12'd0,    12'd0,    1'b0, '0}
		};

		phase_plan = '{
			'{GAIN_RESET, 1'b0, IDLE_NONE, REFILL_NONE},
			'{16'hFFFF,   1'b0, IDLE_SEND, REFILL_FLAT},
			'{16'h0000,   1'b0, IDLE_RECV, REFILL_NONE},
			'{16'h0000,   1'b1, IDLE_BOTH, REFILL_NONE},
			'{16'h0001,   1'b0, IDLE_NONE, REFILL_NARROW},
			'{16'h0000,   1'b1, IDLE_SEND, REFILL_NONE},
			'{16'h0000,   1'b1, IDLE_RECV, REFILL_NONE}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_item(dir_tbl[r].cmd, dir_tbl[r].line, dir_tbl[r].neut,
			          dir_tbl[r].typed, dir_tbl[r].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			g = phase_plan[p].rand_gain ? GAIN_W'($urandom_range(0, 65535))
			                            : phase_plan[p].gain;
			cfg_write_data <= g;
			cfg_write_en <= 1'b1;
			@(posedge clk);
			cfg_write_en <= 1'b0;
			gain_now = g;
			idle_mode = phase_plan[p].mode;
			if (phase_plan[p].refill != REFILL_NONE) begin
				refill_window(phase_plan[p].refill);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(0, 12);
				repeat (burst) send_random_store();
				send_item(CMD_QUERY, CODE_W'($urandom_range(0, 4095)),
				          CODE_W'($urandom_range(0, 4095)), 1'b0, '0);
				sent += burst + 1;
			end
		end

		settle_block();
		if (mismatch_count == 0 && pending_readings.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/wpdm_pkg.sv
sv/wpdm_ring.sv
sv/wpdm_mul.sv
sv/windowed_differential_peak_meter_unit.sv
sv/wpdm_checker.sv
test/tb.sv
